/* src/rvex_pkg.sv */
// ----------------------------------------------------------------------------
// rvex_pkg: shared types and constants of the RV32I subset executor
// Opcodes, function codes, status codes and the execute result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package rvex_pkg;

	// Fixed field widths
	localparam int unsigned XLEN       = 32;
	localparam int unsigned REG_AW     = 5;
	localparam int unsigned MEM_ADDR_W = 12;

	// Program counter increment
	localparam logic [XLEN-1:0] PC_STEP = 32'd4;

	// Major opcodes
	localparam logic [6:0] OP_R      = 7'h33;
	localparam logic [6:0] OP_I      = 7'h13;
	localparam logic [6:0] OP_LOAD   = 7'h03;
	localparam logic [6:0] OP_STORE  = 7'h23;
	localparam logic [6:0] OP_BRANCH = 7'h63;
	localparam logic [6:0] OP_JALR   = 7'h67;

	// funct3 codes
	localparam logic [2:0] F3_ADD_SUB = 3'd0;
	localparam logic [2:0] F3_XOR     = 3'd4;
	localparam logic [2:0] F3_SR      = 3'd5;
	localparam logic [2:0] F3_ADDI    = 3'd0;
	localparam logic [2:0] F3_ANDI    = 3'd7;
	localparam logic [2:0] F3_WORD    = 3'd2;
	localparam logic [2:0] F3_BLT     = 3'd4;

	// funct7 codes
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	// Result status
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_UNKNOWN = 2'd1,
		ST_HALT    = 2'd2
	} status_t;

	// Execute stage result, carried into the memory/writeback stage
	typedef struct packed {
		logic              wr;       // register write (rd != x0)
		logic [REG_AW-1:0] rd;       // destination, zero when no write
		logic [XLEN-1:0]   value;    // ALU/link value, zero for loads
		logic              is_load;  // value comes from the data store
		logic              mw;       // store writes the data store
		logic [XLEN-1:0]   ea;       // effective address, zero for non-memory ops
		logic [XLEN-1:0]   mdata;    // store data, zero otherwise
		logic [XLEN-1:0]   npc;      // next program counter
		status_t           status;
	} exec_res_t;

endpackage

`default_nettype wire

/* src/rvex_regfile.sv */
// ----------------------------------------------------------------------------
// rvex_regfile: general register file
// Two synchronous read ports, one write port. Per-entry valid flags make
// never-written entries (and x0) read as zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module rvex_regfile (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           rd_en,
	input  wire logic [rvex_pkg::REG_AW-1:0]    ra1,
	input  wire logic [rvex_pkg::REG_AW-1:0]    ra2,
	output logic      [rvex_pkg::XLEN-1:0]      rd1,
	output logic      [rvex_pkg::XLEN-1:0]      rd2,
	input  wire logic                           we,
	input  wire logic [rvex_pkg::REG_AW-1:0]    wa,
	input  wire logic [rvex_pkg::XLEN-1:0]      wd
);
	import rvex_pkg::*;

	localparam int unsigned NREG = 2 ** REG_AW;

	logic [XLEN-1:0] mem [NREG];
	logic [NREG-1:0] vld_q;
	logic            vld1_q;
	logic            vld2_q;
	logic [XLEN-1:0] dat1_q;
	logic [XLEN-1:0] dat2_q;

	// Storage array and registered read data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			dat1_q <= mem[ra1];
			dat2_q <= mem[ra2];
		end
	end

	// Valid flags, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			vld1_q <= 1'b0;
			vld2_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[wa] <= 1'b1;
			end
			if (rd_en) begin
				vld1_q <= vld_q[ra1];
				vld2_q <= vld_q[ra2];
			end
		end
	end

	assign rd1 = vld1_q ? dat1_q : '0;
	assign rd2 = vld2_q ? dat2_q : '0;

endmodule

`default_nettype wire

/* src/rvex_dmem.sv */
// ----------------------------------------------------------------------------
// rvex_dmem: word-indexed data store
// Single-port-write, single-read synchronous memory. After reset it sweeps
// every word to zero, one per cycle, and reports busy meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module rvex_dmem #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	output logic                           busy,
	input  wire logic                      rd_en,
	input  wire logic [AW-1:0]             rd_idx,
	output logic      [rvex_pkg::XLEN-1:0] rd_data,
	input  wire logic                      wr_en,
	input  wire logic [AW-1:0]             wr_idx,
	input  wire logic [rvex_pkg::XLEN-1:0] wr_data
);
	import rvex_pkg::*;

	logic [XLEN-1:0] mem [DEPTH];
	logic [XLEN-1:0] rdata_q;
	logic            clearing_q;
	logic [AW-1:0]   clr_idx_q;

	// Clear sweep control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_idx_q  <= '0;
		end else if (clearing_q) begin
			clr_idx_q <= clr_idx_q + AW'(1);
			if (clr_idx_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// Memory array: sweep write has priority, no accesses arrive meanwhile
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem[clr_idx_q] <= '0;
		end else if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_idx];
		end
	end

	assign busy    = clearing_q;
	assign rd_data = rdata_q;

endmodule

`default_nettype wire

/* src/rvex_exec.sv */
// ----------------------------------------------------------------------------
// rvex_exec: decode and execute
// Decodes one instruction, forms immediates, computes ALU result, effective
// address, branch/jump target and status.
// ----------------------------------------------------------------------------
`default_nettype none

module rvex_exec (
	input  wire logic [rvex_pkg::XLEN-1:0] instr,
	input  wire logic [rvex_pkg::XLEN-1:0] pc,
	input  wire logic [rvex_pkg::XLEN-1:0] op_a,
	input  wire logic [rvex_pkg::XLEN-1:0] op_b,
	output rvex_pkg::exec_res_t            res
);
	import rvex_pkg::*;

	logic [6:0]        opc;
	logic [REG_AW-1:0] rd;
	logic [2:0]        f3;
	logic [6:0]        f7;
	logic [XLEN-1:0]   imm_i;
	logic [XLEN-1:0]   imm_s;
	logic [XLEN-1:0]   imm_b;
	logic [XLEN-1:0]   pc4;
	logic [XLEN-1:0]   sum_i;
	logic              wr_c;
	logic [XLEN-1:0]   val_c;
	logic              wr_eff;

	// Field and immediate decode
	assign opc   = instr[6:0];
	assign rd    = instr[11:7];
	assign f3    = instr[14:12];
	assign f7    = instr[31:25];
	assign imm_i = {{20{instr[31]}}, instr[31:20]};
	assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
	assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
	assign pc4   = pc + PC_STEP;
	assign sum_i = op_a + imm_i;

	// Instruction execute
	always_comb begin
		wr_c          = 1'b0;
		val_c         = '0;
		res.is_load   = 1'b0;
		res.mw        = 1'b0;
		res.ea        = '0;
		res.mdata     = '0;
		res.npc       = pc4;
		res.status    = ST_OK;
		unique case (opc)
			OP_R: begin
				if (f3 == F3_ADD_SUB && f7 == F7_BASE) begin
					wr_c  = 1'b1;
					val_c = op_a + op_b;
				end else if (f3 == F3_ADD_SUB && f7 == F7_ALT) begin
					wr_c  = 1'b1;
					val_c = op_a - op_b;
				end else if (f3 == F3_XOR && f7 == F7_BASE) begin
					wr_c  = 1'b1;
					val_c = op_a ^ op_b;
				end else if (f3 == F3_SR && f7 == F7_ALT) begin
					wr_c  = 1'b1;
					val_c = $unsigned($signed(op_a) >>> op_b[4:0]);
				end else begin
					res.status = ST_HALT;
				end
			end
			OP_I: begin
				if (f3 == F3_ADDI) begin
					wr_c  = 1'b1;
					val_c = sum_i;
				end else if (f3 == F3_ANDI) begin
					wr_c  = 1'b1;
					val_c = op_a & imm_i;
				end else begin
					res.status = ST_HALT;
				end
			end
			OP_LOAD: begin
				if (f3 == F3_WORD) begin
					wr_c        = 1'b1;
					res.is_load = 1'b1;
					res.ea      = sum_i;
				end else begin
					res.status = ST_HALT;
				end
			end
			OP_STORE: begin
				if (f3 == F3_WORD) begin
					res.mw    = 1'b1;
					res.ea    = op_a + imm_s;
					res.mdata = op_b;
				end else begin
					res.status = ST_HALT;
				end
			end
			OP_BRANCH: begin
				if (f3 == F3_BLT) begin
					if ($signed(op_a) < $signed(op_b)) begin
						res.npc = pc + imm_b;
					end
				end else begin
					res.status = ST_HALT;
				end
			end
			OP_JALR: begin
				// any funct3 is taken as JALR
				wr_c    = 1'b1;
				val_c   = pc4;
				res.npc = {sum_i[XLEN-1:1], 1'b0};
			end
			default: begin
				res.status = ST_UNKNOWN;
			end
		endcase

		// Writes to x0 are dropped
		wr_eff    = wr_c && (rd != '0);
		res.wr    = wr_eff;
		res.rd    = wr_eff ? rd : '0;
		res.value = wr_eff ? val_c : '0;
	end

endmodule

`default_nettype wire

/* src/rv32i_subset_instruction_executor_top.sv */
// ----------------------------------------------------------------------------
// rv32i_subset_instruction_executor_top: RV32I subset instruction executor
// Executes one instruction word per input transfer and returns one result.
//
// Channels: the input channel carries instr_word, the word fetched at the
// current program counter (next_pc of the previous result, 0 after reset).
// The output channel carries one result per instruction. Both channels use
// valid/stall; a transfer happens on a clock edge with valid high and stall
// low.
// A result reaches the output register by way of stage 1 and stage 2 after
// its input transfer. Throughput: one instruction per cycle while in_stall
// stays low; results of the two stages ahead, load data included, are
// forwarded to the operands, so no dependence stalls the pipeline.
// Reset: pc, register file and data store read as zero. After reset the
// data store is swept to zero; in_stall is high until the sweep ends.
// When out_stall is high the output register holds its result; the two
// pipeline stages behind it fill, then in_stall rises.
// DMEM_DEPTH must be a power of two; addresses wrap to its low bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rv32i_subset_instruction_executor_top #(
	parameter int unsigned DMEM_DEPTH = 4096
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// input channel
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [31:0]                     instr_word,
	// output channel
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [31:0]                          pc_of_instr,
	output logic [31:0]                          next_pc,
	output logic                                 reg_write,
	output logic [4:0]                           write_reg,
	output logic [31:0]                          write_value,
	output logic                                 mem_write,
	output logic [rvex_pkg::MEM_ADDR_W-1:0]      mem_addr,
	output logic [31:0]                          mem_data,
	output logic [1:0]                           status
);
	import rvex_pkg::*;

	localparam int unsigned AW = $clog2(DMEM_DEPTH);

	// Handshake and pipeline control
	logic            accept;
	logic            dm_busy;
	logic            out_free;
	logic            s2_free;
	logic            s1_free;
	logic            s1_adv;
	logic            s2_adv;

	// Stage 1: instruction with register read in flight
	logic            vld_s1;
	logic [XLEN-1:0] instr_s1;
	logic [XLEN-1:0] pc_s1;
	logic [XLEN-1:0] pc_q;
	logic [XLEN-1:0] rf_rd1;
	logic [XLEN-1:0] rf_rd2;
	logic [XLEN-1:0] op_a;
	logic [XLEN-1:0] op_b;
	exec_res_t       ex;

	// Stage 2: executed, data store read in flight
	logic            vld_s2;
	exec_res_t       res_s2;
	logic [XLEN-1:0] pc_s2;
	logic [AW-1:0]   midx_s2;
	logic [XLEN-1:0] dm_rdata;
	logic [XLEN-1:0] s2_wval;

	// Last register write, bypass for a read at the same edge
	logic              wb_vld_q;
	logic [REG_AW-1:0] wb_rd_q;
	logic [XLEN-1:0]   wb_data_q;

	// Output register
	logic              out_vld_q;
	logic [XLEN-1:0]   out_pc_q;
	logic [XLEN-1:0]   out_npc_q;
	logic              out_wr_q;
	logic [REG_AW-1:0] out_rd_q;
	logic [XLEN-1:0]   out_wval_q;
	logic              out_mw_q;
	logic [AW-1:0]     out_midx_q;
	logic [XLEN-1:0]   out_mdata_q;
	status_t           out_status_q;

	// Stage advance: each stage moves when the one ahead frees up
	assign out_free = !out_vld_q || !out_stall;
	assign s2_adv   = vld_s2 && out_free;
	assign s2_free  = !vld_s2 || out_free;
	assign s1_adv   = vld_s1 && s2_free;
	assign s1_free  = !vld_s1 || s2_free;
	assign in_stall = dm_busy || !s1_free;
	assign accept   = in_valid && !in_stall;

	// Register file, read at the input transfer
	rvex_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.ra1    (instr_word[19:15]),
		.ra2    (instr_word[24:20]),
		.rd1    (rf_rd1),
		.rd2    (rf_rd2),
		.we     (s2_adv && res_s2.wr),
		.wa     (res_s2.rd),
		.wd     (s2_wval)
	);

	// Operand forwarding: stage 2 first, then the last write
	always_comb begin
		if (vld_s2 && res_s2.wr && res_s2.rd == instr_s1[19:15]) begin
			op_a = s2_wval;
		end else if (wb_vld_q && wb_rd_q == instr_s1[19:15]) begin
			op_a = wb_data_q;
		end else begin
			op_a = rf_rd1;
		end
		if (vld_s2 && res_s2.wr && res_s2.rd == instr_s1[24:20]) begin
			op_b = s2_wval;
		end else if (wb_vld_q && wb_rd_q == instr_s1[24:20]) begin
			op_b = wb_data_q;
		end else begin
			op_b = rf_rd2;
		end
	end

	rvex_exec u_exec (
		.instr (instr_s1),
		.pc    (pc_s1),
		.op_a  (op_a),
		.op_b  (op_b),
		.res   (ex)
	);

	// Data store, accessed as stage 1 moves into stage 2
	rvex_dmem #(
		.DEPTH (DMEM_DEPTH),
		.AW    (AW)
	) u_dmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.busy    (dm_busy),
		.rd_en   (s1_adv && ex.is_load),
		.rd_idx  (ex.ea[AW-1:0]),
		.rd_data (dm_rdata),
		.wr_en   (s1_adv && ex.mw),
		.wr_idx  (ex.ea[AW-1:0]),
		.wr_data (ex.mdata)
	);

	// Final write value of stage 2
	always_comb begin
		if (!res_s2.wr) begin
			s2_wval = '0;
		end else if (res_s2.is_load) begin
			s2_wval = dm_rdata;
		end else begin
			s2_wval = res_s2.value;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
			wb_vld_q  <= 1'b0;
			pc_q      <= '0;
		end else begin
			if (s1_free) begin
				vld_s1 <= accept;
			end
			if (s2_free) begin
				vld_s2 <= vld_s1;
			end
			if (out_free) begin
				out_vld_q <= vld_s2;
			end
			if (s2_adv && res_s2.wr) begin
				wb_vld_q <= 1'b1;
			end
			if (s1_adv) begin
				pc_q <= ex.npc;
			end
		end
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1 <= instr_word;
			pc_s1    <= vld_s1 ? ex.npc : pc_q;
		end
		if (s1_adv) begin
			res_s2  <= ex;
			pc_s2   <= pc_s1;
			midx_s2 <= ex.ea[AW-1:0];
		end
		if (s2_adv && res_s2.wr) begin
			wb_rd_q   <= res_s2.rd;
			wb_data_q <= s2_wval;
		end
		if (s2_adv) begin
			out_pc_q     <= pc_s2;
			out_npc_q    <= res_s2.npc;
			out_wr_q     <= res_s2.wr;
			out_rd_q     <= res_s2.rd;
			out_wval_q   <= s2_wval;
			out_mw_q     <= res_s2.mw;
			out_midx_q   <= midx_s2;
			out_mdata_q  <= res_s2.mdata;
			out_status_q <= res_s2.status;
		end
	end

	// Output ports
	assign out_valid   = out_vld_q;
	assign pc_of_instr = out_pc_q;
	assign next_pc     = out_npc_q;
	assign reg_write   = out_wr_q;
	assign write_reg   = out_rd_q;
	assign write_value = out_wval_q;
	assign mem_write   = out_mw_q;
	assign mem_addr    = MEM_ADDR_W'(out_midx_q);
	assign mem_data    = out_mdata_q;
	assign status      = out_status_q;

endmodule

`default_nettype wire
